// ----- design/sha512_pkg.sv -----
// Package for the streaming SHA-512 core: constants, round table, command structs.
// No dependencies; used by every module of the core.
package sha512_pkg;

	localparam int BYTE_COUNT_BITS_DEF = 61;
	localparam int ROUNDS = 80;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [6:0] LEN_OFFSET = 7'd112;

	typedef logic [63:0] word_t;

	localparam word_t IV [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam word_t ROUND_K [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	// Source of the byte written into the block buffer.
	typedef enum logic [1:0] {
		SRC_MSG = 2'd0,
		SRC_PAD = 2'd1,
		SRC_ZERO = 2'd2,
		SRC_LEN = 2'd3
	} byte_src_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic      wr_byte;    // write one byte into the block buffer
		byte_src_t src;
		logic      cnt_inc;    // count a message byte
		logic      cmp_start;  // copy hash into working variables
		logic      cmp_round;  // perform one round
		logic      cmp_final;  // add working variables into hash
		logic      reinit;     // reload IV, clear counters
		logic      out_load;   // latch digest word at out_idx
		logic [2:0] out_idx;
	} dp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic block_full;  // the byte written now completes the block
		logic at_len;      // fill count equals the length offset
		logic last_round;  // current round is the last
		logic rd_ready;    // schedule read data valid for current round
	} dp_stat_t;

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

endpackage

// ----- design/sha512_ctrl.sv -----
// Controller for the streaming SHA-512 core: handshakes, padding sequence, rounds, output.
// Depends on sha512_pkg.
module sha512_ctrl
	import sha512_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     byte_valid,
	input  logic     end_of_message,
	output logic     out_valid,
	input  logic     out_ready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PAD   = 7'b0000010,
		ST_ZERO  = 7'b0000100,
		ST_LEN   = 7'b0001000,
		ST_CMP   = 7'b0010000,
		ST_FIN   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q, state_nx;
	logic [2:0] out_cnt_q, out_cnt_nx;
	logic       out_valid_q, out_valid_nx;
	state_t     ret_q, ret_nx;         // where to resume after compression

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx     = state_q;
		out_cnt_nx   = out_cnt_q;
		out_valid_nx = out_valid_q;
		ret_nx       = ret_q;
		cmd          = '0;
		cmd.src      = SRC_MSG;
		cmd.out_idx  = out_cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.wr_byte = byte_valid;
					cmd.cnt_inc = byte_valid;
					if (byte_valid && stat.block_full) begin
						cmd.cmp_start = 1'b1;
						state_nx = ST_CMP;
						ret_nx = end_of_message ? ST_PAD : ST_IDLE;
					end else if (end_of_message) begin
						state_nx = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.wr_byte = 1'b1;
				cmd.src = SRC_PAD;
				if (stat.block_full) begin
					cmd.cmp_start = 1'b1;
					state_nx = ST_CMP;
					ret_nx = ST_ZERO;
				end else begin
					state_nx = ST_ZERO;
				end
			end
			ST_ZERO: begin
				if (stat.at_len) begin
					state_nx = ST_LEN;
				end else begin
					cmd.wr_byte = 1'b1;
					cmd.src = SRC_ZERO;
					if (stat.block_full) begin
						cmd.cmp_start = 1'b1;
						state_nx = ST_CMP;
						ret_nx = ST_ZERO;
					end
				end
			end
			ST_LEN: begin
				cmd.wr_byte = 1'b1;
				cmd.src = SRC_LEN;
				if (stat.block_full) begin
					cmd.cmp_start = 1'b1;
					state_nx = ST_CMP;
					ret_nx = ST_OUT;
				end
			end
			ST_CMP: begin
				cmd.cmp_round = stat.rd_ready;
				if (stat.rd_ready && stat.last_round) begin
					state_nx = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.cmp_final = 1'b1;
				if (ret_q == ST_OUT) begin
					out_cnt_nx = '0;
				end
				state_nx = ret_q;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					if (out_valid_q && out_cnt_q == 3'd7) begin
						out_valid_nx = 1'b0;
						cmd.reinit = 1'b1;
						state_nx = ST_IDLE;
					end else begin
						cmd.out_load = 1'b1;
						cmd.out_idx = out_valid_q ? out_cnt_q + 3'd1 : out_cnt_q;
						out_cnt_nx = cmd.out_idx;
						out_valid_nx = 1'b1;
					end
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			ret_q       <= ST_IDLE;
		end else begin
			state_q     <= state_nx;
			out_cnt_q   <= out_cnt_nx;
			out_valid_q <= out_valid_nx;
			ret_q       <= ret_nx;
		end
	end

	// Results only appear in the output state.
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == ST_OUT)
		else $error("digest word valid outside output state");

	// No input is taken while a block is being compressed.
	a_no_in_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> !in_ready)
		else $error("input ready during compression");

	// A held result keeps its index while stalled.
	a_idx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(out_cnt_q))
		else $error("digest index moved while stalled");

endmodule

// ----- design/sha512_dp.sv -----
// Datapath of the streaming SHA-512 core: block buffer, schedule, rounds, hash state.
// Depends on sha512_pkg.
module sha512_dp
	import sha512_pkg::*;
#(
	parameter int BYTE_COUNT_BITS = BYTE_COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  msg_byte,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output logic [63:0] digest_word,
	output logic [2:0]  digest_idx,
	output logic        last_word
);

	// Block buffer, one 64-bit word per eight bytes, read as a memory.
	logic [63:0] blk_mem [16];
	logic [63:0] blk_rd_q;
	logic [63:0] asm_q;           // word being assembled
	logic [6:0]  fill_q;
	logic [BYTE_COUNT_BITS-1:0] count_q;
	word_t       hash_q [8];
	word_t       wv_q [8];
	word_t       ring_q [16];
	logic [6:0]  rnd_q;           // round index, 0..80
	logic        rd_valid_q;
	logic [63:0] out_q;
	logic [2:0]  oidx_q;

	logic [7:0]  wr_data;
	logic [63:0] bits;
	logic [63:0] asm_nx;
	word_t       w_cur, s0, s1, t1, t2, e, a;
	logic [3:0]  ti;

	assign bits = 64'(count_q) << 3;

	// The length field is sixteen bytes: the upper eight are zero, the lower eight
	// carry the bit count, most significant byte first.
	always_comb begin
		case (cmd.src)
			SRC_MSG:  wr_data = msg_byte;
			SRC_PAD:  wr_data = PAD_BYTE;
			SRC_ZERO: wr_data = 8'h00;
			default:  wr_data = fill_q[3] ? bits[8'(7 - fill_q[2:0]) * 8 +: 8] : 8'h00;
		endcase
	end

	assign asm_nx = {asm_q[55:0], wr_data};

	assign stat.block_full = (fill_q == 7'd127);
	assign stat.at_len     = (fill_q == LEN_OFFSET);
	assign stat.last_round = (rnd_q == 7'(ROUNDS - 1));
	assign stat.rd_ready   = rd_valid_q || (rnd_q >= 7'd16);

	always_ff @(posedge clk) begin
		if (cmd.wr_byte && fill_q[2:0] == 3'd7) begin
			blk_mem[fill_q[6:3]] <= asm_nx;
		end
		blk_rd_q <= blk_mem[rnd_q[3:0]];
	end

	assign ti = rnd_q[3:0];

	always_comb begin
		s0 = rotr(ring_q[4'(ti + 4'd1)], 1) ^ rotr(ring_q[4'(ti + 4'd1)], 8)
		   ^ (ring_q[4'(ti + 4'd1)] >> 7);
		s1 = rotr(ring_q[4'(ti + 4'd14)], 19) ^ rotr(ring_q[4'(ti + 4'd14)], 61)
		   ^ (ring_q[4'(ti + 4'd14)] >> 6);
		if (rnd_q < 7'd16) begin
			w_cur = blk_rd_q;
		end else begin
			w_cur = ring_q[ti] + s0 + ring_q[4'(ti + 4'd9)] + s1;
		end
		a = wv_q[0];
		e = wv_q[4];
		t1 = wv_q[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
		   + ((e & wv_q[5]) ^ (~e & wv_q[6])) + ROUND_K[rnd_q] + w_cur;
		t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
		   + ((a & wv_q[1]) ^ (a & wv_q[2]) ^ (wv_q[1] & wv_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			count_q    <= '0;
			rnd_q      <= '0;
			rd_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) hash_q[i] <= IV[i];
		end else begin
			if (cmd.wr_byte) begin
				fill_q <= fill_q + 7'd1;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.cmp_start) begin
				rnd_q <= '0;
				rd_valid_q <= 1'b0;
				for (int i = 0; i < 8; i++) wv_q[i] <= hash_q[i];
			end else if (cmd.cmp_round) begin
				rnd_q <= rnd_q + 7'd1;
				rd_valid_q <= 1'b0;
				ring_q[ti] <= w_cur;
				wv_q[7] <= wv_q[6];
				wv_q[6] <= wv_q[5];
				wv_q[5] <= wv_q[4];
				wv_q[4] <= wv_q[3] + t1;
				wv_q[3] <= wv_q[2];
				wv_q[2] <= wv_q[1];
				wv_q[1] <= wv_q[0];
				wv_q[0] <= t1 + t2;
			end else begin
				// Without a round, the registered buffer read settles and is marked valid.
				rd_valid_q <= 1'b1;
			end
			if (cmd.cmp_final) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + wv_q[i];
			end
			if (cmd.reinit) begin
				fill_q  <= '0;
				count_q <= '0;
				for (int i = 0; i < 8; i++) hash_q[i] <= IV[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_byte) begin
			asm_q <= asm_nx;
		end
		if (cmd.out_load) begin
			out_q  <= hash_q[cmd.out_idx];
			oidx_q <= cmd.out_idx;
		end
	end

	assign digest_word = out_q;
	assign digest_idx  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);

endmodule

// ----- design/sha512_stream_hash_core.sv -----
// Streaming SHA-512 core, top level: joins controller and datapath; depends on sha512_pkg.
// A request is taken while the core is idle; one that completes a block holds the input off
// through the 80 rounds (each of the first sixteen waits for a buffer read) and the fold.
// End of message: padding writes a byte at a time, up to two compressions follow, and the
// first digest word follows in the output state, then one word a cycle while out_ready is high.
// Reset (arst_n low, asynchronous) loads the initial hash values and clears all counts.
module sha512_stream_hash_core
	import sha512_pkg::*;
#(
	parameter int BYTE_COUNT_BITS = BYTE_COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  msg_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_word,
	output logic [2:0]  digest_idx,
	output logic        last_word
);

	// The controller sequences each request: bytes go straight into the block buffer,
	// a full block starts the 80-round compression, and an end marker walks the
	// padding, the length field and the eight-word output.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	sha512_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.byte_valid(byte_valid), .end_of_message(end_of_message),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .stat(stat)
	);

	// The datapath holds the hash state, buffer, schedule ring and round logic.
	sha512_dp #(.BYTE_COUNT_BITS(BYTE_COUNT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.msg_byte(msg_byte),
		.cmd(cmd), .stat(stat),
		.digest_word(digest_word), .digest_idx(digest_idx), .last_word(last_word)
	);

endmodule

// ----- bench/tb_sha512_stream_hash_core.sv -----
// Self-checking bench for the streaming SHA-512 core: drives requests of message bytes,
// predicts the eight digest words of each message and compares every word that comes out.
// Depends on sha512_pkg for the initial hash values, round constants and padding constants.
`timescale 1ns / 1ps

module tb_sha512_stream_hash_core;
	import sha512_pkg::*;

	// One digest word as the core should deliver it.
	typedef struct {
		logic [63:0] digest;
		logic [2:0]  index;
		logic        last;
	} digest_exp_t;

	// One row of the directed table. When check_known is set the predicted first digest word
	// of the message finished by this row is also compared with known_h0.
	typedef struct {
		logic [7:0]  data;
		logic        has_byte;
		logic        ends;
		logic        check_known;
		logic [63:0] known_h0;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 12;
	localparam int RANDOM_ITEMS = 218;
	localparam longint CYCLE_LIMIT = 2000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  msg_byte;
	logic        byte_valid;
	logic        end_of_message;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] digest_word;
	logic [2:0]  digest_idx;
	logic        last_word;

	sha512_stream_hash_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.msg_byte(msg_byte),
		.byte_valid(byte_valid),
		.end_of_message(end_of_message),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digest_word(digest_word),
		.digest_idx(digest_idx),
		.last_word(last_word)
	);

	// Predictor state: running hash, partial block and message byte count.
	logic [63:0] hash_state [8];
	logic [7:0]  block_bytes [128];
	int          block_fill;
	logic [60:0] byte_total;

	digest_exp_t pending_words [$];
	int          error_count = 0;
	bit          stimulus_done = 0;
	bit          long_hold_done = 0;
	longint      cycle_count = 0;

	// Known SHA-512 first words: empty message, "abc", and one 0x00 byte.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, 64'hcf83e1357eefb8bd},
		'{8'h61, 1'b1, 1'b0, 1'b0, 64'h0},
		'{8'hff, 1'b0, 1'b0, 1'b0, 64'h0},
		'{8'h62, 1'b1, 1'b0, 1'b0, 64'h0},
		'{8'h63, 1'b1, 1'b1, 1'b1, 64'hddaf35a193617aba},
		'{8'h00, 1'b1, 1'b0, 1'b0, 64'h0},
		'{8'h00, 1'b0, 1'b1, 1'b1, 64'hb8244d028981d693},
		'{8'hff, 1'b1, 1'b0, 1'b0, 64'h0},
		'{8'h55, 1'b1, 1'b0, 1'b0, 64'h0},
		'{8'haa, 1'b1, 1'b1, 1'b0, 64'h0},
		'{8'hff, 1'b1, 1'b1, 1'b0, 64'h0},
		'{8'h00, 1'b0, 1'b1, 1'b1, 64'hcf83e1357eefb8bd}
	};

	// The clock runs at a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	// Eighty rounds over the buffered block, folded into the running hash.
	function automatic void fold_block();
		logic [63:0] sched [80];
		logic [63:0] v [8];
		logic [63:0] t1, t2;
		for (int t = 0; t < 16; t++) begin
			sched[t] = '0;
			for (int i = 0; i < 8; i++)
				sched[t] = (sched[t] << 8) | 64'(block_bytes[t * 8 + i]);
		end
		for (int t = 16; t < 80; t++)
			sched[t] = sched[t - 16] + sched[t - 7]
				+ (ror64(sched[t - 15], 1) ^ ror64(sched[t - 15], 8) ^ (sched[t - 15] >> 7))
				+ (ror64(sched[t - 2], 19) ^ ror64(sched[t - 2], 61) ^ (sched[t - 2] >> 6));
		for (int i = 0; i < 8; i++)
			v[i] = hash_state[i];
		for (int t = 0; t < 80; t++) begin
			t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + sched[t];
			t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] = hash_state[i] + v[i];
	endfunction

	function automatic void append_byte(input logic [7:0] b);
		block_bytes[block_fill] = b;
		block_fill++;
		if (block_fill == 128) begin
			fold_block();
			block_fill = 0;
		end
	endfunction

	function automatic void restart_message();
		for (int i = 0; i < 8; i++)
			hash_state[i] = IV[i];
		block_fill = 0;
		byte_total = '0;
	endfunction

	// Works out what one accepted request does; a finished message queues eight words.
	function automatic void hash_request(input logic [7:0] b, input logic has_byte,
			input logic ends);
		logic [63:0] bit_len;
		digest_exp_t w;
		if (has_byte) begin
			append_byte(b);
			byte_total = byte_total + 61'd1;
		end
		if (ends) begin
			bit_len = {byte_total, 3'b000};
			append_byte(PAD_BYTE);
			while (block_fill != int'(LEN_OFFSET))
				append_byte(8'h00);
			for (int i = 0; i < 8; i++)
				append_byte(8'h00);
			for (int i = 0; i < 8; i++)
				append_byte(bit_len[63 - 8 * i -: 8]);
			for (int i = 0; i < 8; i++) begin
				w.digest = hash_state[i];
				w.index = 3'(i);
				w.last = (i == 7);
				pending_words.push_back(w);
			end
			restart_message();
		end
	endfunction

	// Offers one request after a random gap, then waits until the core takes it.
	// Valid only drops when a gap follows, so back-to-back requests keep it high.
	task automatic send_request(input logic [7:0] b, input logic has_byte, input logic ends);
		int gap;
		gap = $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		msg_byte <= b;
		byte_valid <= has_byte;
		end_of_message <= ends;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		hash_request(b, has_byte, ends);
		@(negedge clk);
	endtask

	// Mostly well-formed messages of random length and content; a few carry idle
	// requests without a byte. Occasionally a long one crosses block boundaries.
	task automatic send_random_traffic();
		int sent, len;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(110, 260);
			else
				len = $urandom_range(0, 20);
			if (len > RANDOM_ITEMS - sent - 1)
				len = RANDOM_ITEMS - sent - 1;
			if (len < 0)
				len = 0;
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 7) == 0) begin
					send_request(8'($urandom), 1'b0, 1'b0);
					sent++;
				end
				send_request(8'($urandom), 1'b1, 1'b0);
				sent++;
			end
			// The closing request either brings the last byte or carries none.
			send_request(8'($urandom), 1'($urandom), 1'b1);
			sent++;
		end
	endtask

	// Stimulus: reset, the directed table, then random messages.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		msg_byte = '0;
		byte_valid = 1'b0;
		end_of_message = 1'b0;
		restart_message();
		for (int i = 0; i < 128; i++)
			block_bytes[i] = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			send_request(directed_rows[r].data, directed_rows[r].has_byte,
				directed_rows[r].ends);
			if (directed_rows[r].check_known &&
					pending_words[pending_words.size() - 8].digest !=
					directed_rows[r].known_h0) begin
				$display("%0t: known digest row %0d expected %h, predicted %h", $time, r,
					directed_rows[r].known_h0, pending_words[pending_words.size() - 8].digest);
				error_count++;
			end
		end
		send_random_traffic();
		in_valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	// Receiver: a random stall per word, and one long hold-off while requests pile up.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && cycle_count > 200) begin
				out_ready <= 1'b0;
				repeat (600) @(negedge clk);
				long_hold_done = 1'b1;
			end
			stall = $urandom_range(0, 8);
			if ($urandom_range(0, 3) == 0)
				stall = 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Checks each delivered word against the oldest expected one.
	always @(posedge clk) begin
		digest_exp_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected digest word %h index %0d", $time, digest_word,
					digest_idx);
				error_count++;
			end else begin
				w = pending_words.pop_front();
				if (digest_word !== w.digest) begin
					$display("%0t: digest_word expected %h, got %h", $time, w.digest,
						digest_word);
					error_count++;
				end
				if (digest_idx !== w.index) begin
					$display("%0t: digest_idx expected %0d, got %0d", $time, w.index,
						digest_idx);
					error_count++;
				end
				if (last_word !== w.last) begin
					$display("%0t: last_word expected %b, got %b", $time, w.last, last_word);
					error_count++;
				end
			end
		end
	end

	// Run control: the cycle limit, and the end once every word has come out.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		wait (stimulus_done);
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
